FILE: src/three_level_strict_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strict priority queue core
// Checks compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_STRICT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define THREE_LEVEL_STRICT_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/splq_pkg.sv
// ----------------------------------------------------------------------------
// splq_pkg
// Types, codes and helpers shared by the strict priority queue modules.
// ----------------------------------------------------------------------------
package splq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_WIDTH   = 16;
  localparam int NUM_CLASSES = 3;
  localparam int NUM_ENTRIES = NUM_CLASSES * QUEUE_DEPTH;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_ENTRIES);

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [1:0] CLS_RED     = 2'd0;
  localparam logic [1:0] CLS_YELLOW  = 2'd1;
  localparam logic [1:0] CLS_GREEN   = 2'd2;
  localparam logic [1:0] CLS_INVALID = 2'd3;

  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_POPPED  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [1:0]  urgency_class;
    logic [15:0] entry_tag;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] served_tag;
    logic [1:0]  served_class;
    logic        all_empty;
  } out_word_t;

  // tag store access for one step
  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [TAG_WIDTH-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
  } ram_req_t;

  // per-step result without the tag, which comes from the store
  typedef struct packed {
    status_t    status;
    logic [1:0] served_class;
    logic       all_empty;
  } step_res_t;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] pos);
    return (pos == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pos + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] tag_addr(input logic [1:0]       cls,
                                                 input logic [PTR_W-1:0] pos);
    return ADDR_W'(cls) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
  endfunction

endpackage

FILE: src/splq_tag_ram.sv
// ----------------------------------------------------------------------------
// splq_tag_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module splq_tag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/splq_ctrl.sv
// ----------------------------------------------------------------------------
// splq_ctrl
// Ring pointers and counts of the three class queues, push/pop decision.
// ----------------------------------------------------------------------------
`include "three_level_strict_priority_queue_core_defines.svh"

module splq_ctrl
  import splq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_word_t  word,
  output ram_req_t  req,
  output step_res_t res
);

  logic [PTR_W-1:0] rd_pos_r [NUM_CLASSES];
  logic [PTR_W-1:0] rd_pos_nxt [NUM_CLASSES];
  logic [PTR_W-1:0] wr_pos_r [NUM_CLASSES];
  logic [PTR_W-1:0] wr_pos_nxt [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_r [NUM_CLASSES];
  logic [CNT_W-1:0] cnt_nxt [NUM_CLASSES];

  logic [1:0] cls;
  logic [1:0] sel;
  logic       hit;

  assign cls = word.urgency_class;

  always_comb begin
    rd_pos_nxt       = rd_pos_r;
    wr_pos_nxt       = wr_pos_r;
    cnt_nxt          = cnt_r;
    req              = '0;
    res.status       = ST_EMPTY;
    res.served_class = CLS_RED;
    sel              = CLS_RED;
    hit              = 1'b0;

    if (word.action == ACT_PUSH) begin
      if (cls == CLS_INVALID) begin
        res.status = ST_IGNORED;
      end else if (cnt_r[cls] == CNT_W'(QUEUE_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        res.status      = ST_PUSHED;
        req.wr_en       = step;
        req.wr_addr     = tag_addr(cls, wr_pos_r[cls]);
        req.wr_data     = TAG_WIDTH'(word.entry_tag);
        wr_pos_nxt[cls] = next_pos(wr_pos_r[cls]);
        cnt_nxt[cls]    = cnt_r[cls] + 1'b1;
      end
    end else begin
      // most urgent non-empty ring wins
      priority if (cnt_r[CLS_RED] != '0) begin
        sel = CLS_RED;
        hit = 1'b1;
      end else if (cnt_r[CLS_YELLOW] != '0) begin
        sel = CLS_YELLOW;
        hit = 1'b1;
      end else if (cnt_r[CLS_GREEN] != '0) begin
        sel = CLS_GREEN;
        hit = 1'b1;
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        res.status       = ST_POPPED;
        res.served_class = sel;
        req.rd_en        = step;
        req.rd_addr      = tag_addr(sel, rd_pos_r[sel]);
        rd_pos_nxt[sel]  = next_pos(rd_pos_r[sel]);
        cnt_nxt[sel]     = cnt_r[sel] - 1'b1;
      end
    end

    res.all_empty = (cnt_nxt[CLS_RED] == '0) && (cnt_nxt[CLS_YELLOW] == '0) &&
                    (cnt_nxt[CLS_GREEN] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        rd_pos_r[i] <= '0;
        wr_pos_r[i] <= '0;
        cnt_r[i]    <= '0;
      end
    end else if (step) begin
      rd_pos_r <= rd_pos_nxt;
      wr_pos_r <= wr_pos_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `SPQ_ASSERT(a_cnt_bound,
    (cnt_r[CLS_RED] <= CNT_W'(QUEUE_DEPTH)) &&
    (cnt_r[CLS_YELLOW] <= CNT_W'(QUEUE_DEPTH)) &&
    (cnt_r[CLS_GREEN] <= CNT_W'(QUEUE_DEPTH)),
    "ring count above depth")
  `SPQ_ASSERT(a_empty_ptrs,
    ((cnt_r[CLS_RED] != '0) || (rd_pos_r[CLS_RED] == wr_pos_r[CLS_RED])) &&
    ((cnt_r[CLS_YELLOW] != '0) || (rd_pos_r[CLS_YELLOW] == wr_pos_r[CLS_YELLOW])) &&
    ((cnt_r[CLS_GREEN] != '0) || (rd_pos_r[CLS_GREEN] == wr_pos_r[CLS_GREEN])),
    "empty ring with split pointers")
  `SPQ_ASSERT(a_one_port, !(req.wr_en && req.rd_en), "read and write in one step")
  `SPQ_ASSERT(a_idle_hold,
    !step |=> $stable(cnt_r[CLS_RED]) && $stable(cnt_r[CLS_YELLOW]) &&
    $stable(cnt_r[CLS_GREEN]),
    "count moved without a step")
  `SPQ_ASSERT_ALWAYS(a_reset_clear,
    !rst_n |=> (cnt_r[CLS_RED] == '0) && (cnt_r[CLS_YELLOW] == '0) &&
    (cnt_r[CLS_GREEN] == '0),
    "counts not cleared by reset")

endmodule

FILE: src/three_level_strict_priority_queue_core.sv
// ----------------------------------------------------------------------------
// three_level_strict_priority_queue_core: three-class strict priority FIFO of tags
// Throughput: one word per cycle while out_ready does not stall the result register.
// Stages: input register, decision, then result register.
// Reset: synchronous, clears ring pointers and counts; tag store is not cleared.
// ----------------------------------------------------------------------------
module three_level_strict_priority_queue_core
  import splq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic      s1_vld_r;
  in_word_t  s1_word_r;
  logic      out_vld_r;
  step_res_t res_r;
  logic      s1_adv;
  ram_req_t  req;
  step_res_t res;
  logic [TAG_WIDTH-1:0] rd_data;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_data;
    end
    if (s1_adv) begin
      res_r <= res;
    end
  end

  splq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .word  (s1_word_r),
    .req   (req),
    .res   (res)
  );

  splq_tag_ram #(
    .WIDTH (TAG_WIDTH),
    .DEPTH (NUM_ENTRIES)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (rd_data)
  );

  // store read data lands with the result register and holds while stalled
  assign out_valid             = out_vld_r;
  assign out_data.status       = res_r.status;
  assign out_data.served_tag   = (res_r.status == ST_POPPED) ? 16'(rd_data) : '0;
  assign out_data.served_class = res_r.served_class;
  assign out_data.all_empty    = res_r.all_empty;

endmodule

FILE: sim/tb_three_level_strict_priority_queue_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_level_strict_priority_queue_core
// Self-checking bench for the three-class strict priority tag queue. A short
// directed table covers empty pops, ignored and refused pushes and the
// priority order. A long random run follows, with bursts biased toward filling
// or draining the rings. Result words are checked against a behavioral model of
// the rings, or against the table for typed rows. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_three_level_strict_priority_queue_core;
  import splq_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 1350;
  localparam int BURST_LEN      = 50;
  localparam int MAX_WAIT       = 5;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    in_word_t    word;
    int unsigned count;
    bit          typed;
    out_word_t   result;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_word_t out_data;

  // ring model
  logic [TAG_WIDTH-1:0] ring_tags [NUM_ENTRIES];
  int unsigned          head_pos  [NUM_CLASSES];
  int unsigned          tail_pos  [NUM_CLASSES];
  int unsigned          ring_fill [NUM_CLASSES];

  out_word_t   awaited_words[$];
  stim_row_t   dir_rows[$];
  out_word_t   predicted;
  out_word_t   want;
  bit          cur_typed;
  out_word_t   cur_typed_result;
  bit          src_quiet;
  bit          rcv_quiet;
  int unsigned idle_cycles;
  int unsigned err_count;

  three_level_strict_priority_queue_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Apply one request word to the rings and return the word the block owes.
  function automatic out_word_t serve_request(input in_word_t req);
    out_word_t   res;
    int unsigned cls;
    bit          found;
    res        = '0;
    res.status = ST_PUSHED;
    cls        = int'(req.urgency_class);
    found      = 1'b0;
    if (req.action == ACT_PUSH) begin
      if (req.urgency_class == CLS_INVALID) begin
        res.status = ST_IGNORED;
      end else if (ring_fill[cls] >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        ring_tags[cls * QUEUE_DEPTH + tail_pos[cls]] = req.entry_tag[TAG_WIDTH-1:0];
        tail_pos[cls]  = (tail_pos[cls] + 1) % QUEUE_DEPTH;
        ring_fill[cls] = ring_fill[cls] + 1;
      end
    end else begin
      res.status = ST_EMPTY;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (!found && ring_fill[c] != 0) begin
          res.served_tag   = 16'(ring_tags[c * QUEUE_DEPTH + head_pos[c]]);
          res.served_class = 2'(c);
          res.status       = ST_POPPED;
          head_pos[c]      = (head_pos[c] + 1) % QUEUE_DEPTH;
          ring_fill[c]     = ring_fill[c] - 1;
          found            = 1'b1;
        end
      end
    end
    res.all_empty = (ring_fill[0] == 0 && ring_fill[1] == 0 && ring_fill[2] == 0);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_typed        = typed;
    cur_typed_result = typed_res;
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic add_row(input logic act, input logic [1:0] cls, input logic [15:0] tag,
                         input int unsigned count, input bit typed, input status_t st,
                         input logic empty);
    stim_row_t row;
    row.word                = '{action: act, urgency_class: cls, entry_tag: tag};
    row.count               = count;
    row.typed               = typed;
    row.result              = '0;
    row.result.status       = st;
    row.result.all_empty    = empty;
    dir_rows.push_back(row);
  endtask

  // result side: random stall ahead of each word, with quiet stretches
  initial begin
    int unsigned stall;
    do @(negedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rcv_quiet = !rcv_quiet;
      stall = rcv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // sample both channels, predict, check, and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = serve_request(in_data);
        awaited_words.push_back(cur_typed ? cur_typed_result : predicted);
      end
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          $error("unexpected result word: status %0d tag %h", out_data.status,
                 out_data.served_tag);
          err_count++;
        end else begin
          want = awaited_words.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_count++;
          end
          if (out_data.served_tag !== want.served_tag) begin
            $error("served_tag: expected %h, got %h", want.served_tag, out_data.served_tag);
            err_count++;
          end
          if (out_data.served_class !== want.served_class) begin
            $error("served_class: expected %0d, got %0d", want.served_class,
                   out_data.served_class);
            err_count++;
          end
          if (out_data.all_empty !== want.all_empty) begin
            $error("all_empty: expected %0b, got %0b", want.all_empty, out_data.all_empty);
            err_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  initial begin
    in_word_t    w;
    int unsigned push_pct;
    int unsigned hot_cls;
    int unsigned pick;
    for (int i = 0; i < NUM_ENTRIES; i++) ring_tags[i] = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_pos[c]  = 0;
      tail_pos[c]  = 0;
      ring_fill[c] = 0;
    end
    err_count   = 0;
    idle_cycles = 0;
    src_quiet   = 1'b0;
    rcv_quiet   = 1'b0;
    cur_typed   = 1'b0;
    push_pct    = 50;
    hot_cls     = 0;

    // act, class, tag, repeat, typed, status, all_empty
    add_row(ACT_POP,  CLS_RED,     16'h0000,  1, 1'b1, ST_EMPTY,   1'b1);
    // pop ignores class and tag
    add_row(ACT_POP,  CLS_INVALID, 16'hFFFF,  1, 1'b1, ST_EMPTY,   1'b1);
    add_row(ACT_PUSH, CLS_INVALID, 16'hFFFF,  1, 1'b1, ST_IGNORED, 1'b1);
    add_row(ACT_PUSH, CLS_GREEN,   16'h0000,  1, 1'b1, ST_PUSHED,  1'b0);
    add_row(ACT_PUSH, CLS_YELLOW,  16'hFFFF,  1, 1'b1, ST_PUSHED,  1'b0);
    add_row(ACT_PUSH, CLS_RED,     16'h8001,  1, 1'b1, ST_PUSHED,  1'b0);
    // red first, then yellow, then green, last pop leaves all empty
    add_row(ACT_POP,  CLS_RED,     16'h0000,  3, 1'b0, ST_POPPED,  1'b0);
    add_row(ACT_PUSH, CLS_YELLOW,  16'h1000, QUEUE_DEPTH, 1'b0, ST_PUSHED, 1'b0);
    add_row(ACT_PUSH, CLS_YELLOW,  16'hFFFF,  1, 1'b1, ST_FULL,    1'b0);
    add_row(ACT_PUSH, CLS_INVALID, 16'h0000,  1, 1'b1, ST_IGNORED, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      for (int unsigned k = 0; k < dir_rows[r].count; k++) begin
        w           = dir_rows[r].word;
        w.entry_tag = dir_rows[r].word.entry_tag + 16'(k);
        send_word(w, dir_rows[r].typed, dir_rows[r].result);
      end
    end

    // bursts lean toward filling or draining so full rings and empty pops recur
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % BURST_LEN == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 15;
          1:       push_pct = 40;
          2:       push_pct = 55;
          3:       push_pct = 80;
          default: push_pct = 97;
        endcase
        hot_cls   = $urandom_range(0, NUM_CLASSES - 1);
        src_quiet = ($urandom_range(0, 3) == 0);
      end
      w.action = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
      pick = $urandom_range(0, 15);
      if (pick == 0)     w.urgency_class = CLS_INVALID;
      else if (pick < 9) w.urgency_class = 2'(hot_cls);
      else               w.urgency_class = 2'($urandom_range(0, NUM_CLASSES - 1));
      case ($urandom_range(0, 9))
        0:       w.entry_tag = 16'h0000;
        1:       w.entry_tag = 16'hFFFF;
        default: w.entry_tag = 16'($urandom);
      endcase
      send_word(w, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
